// ===== rtl/core/iit_pkg.sv =====
package iit_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 6;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHR,
    ST_COPY,
    ST_DONE
  } iit_state_e;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } iit_meta_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic case_sens);
    logic [CHAR_W-1:0] r;
    r = c;
    if (!case_sens && (c inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/iit_pend_buf.sv =====
module iit_pend_buf import iit_pkg::*; #(
  parameter int unsigned NAME_MAX = 32,
  localparam int unsigned CW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [CW-1:0]     waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic [CW-1:0]     raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem [NAME_MAX];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/iit_entry_store.sv =====
module iit_entry_store import iit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned NAME_MAX    = 32,
  localparam int unsigned IW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
  input  logic              clk_i,
  input  logic              chr_we_i,
  input  logic [IW+CW-1:0]  chr_waddr_i,
  input  logic [CHAR_W-1:0] chr_wdata_i,
  input  logic [IW+CW-1:0]  chr_raddr_i,
  output logic [CHAR_W-1:0] chr_rdata_o,
  input  logic              meta_we_i,
  input  logic [IW-1:0]     meta_waddr_i,
  input  iit_meta_t         meta_wdata_i,
  input  logic [IW-1:0]     meta_raddr_i,
  output iit_meta_t         meta_rdata_o
);

  // one row of 2**CW characters per entry
  logic [CHAR_W-1:0] chr_mem  [TABLE_DEPTH << CW];
  iit_meta_t         meta_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (chr_we_i) begin
      chr_mem[chr_waddr_i] <= chr_wdata_i;
    end
    chr_rdata_o <= chr_mem[chr_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we_i) begin
      meta_mem[meta_waddr_i] <= meta_wdata_i;
    end
    meta_rdata_o <= meta_mem[meta_raddr_i];
  end

endmodule

// ===== rtl/core/iit_search_ctrl.sv =====
module iit_search_ctrl import iit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned NAME_MAX    = 32,
  localparam int unsigned IW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  logic              last_i,
  input  logic [CODE_W-1:0] code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  index_o,
  output logic [CODE_W-1:0] entry_code_o,
  output logic              added_o,
  output logic              overflow_o,
  output logic              pend_we_o,
  output logic [CW-1:0]     pend_waddr_o,
  output logic [CHAR_W-1:0] pend_wdata_o,
  output logic [CW-1:0]     pend_raddr_o,
  input  logic [CHAR_W-1:0] pend_rdata_i,
  output logic              chr_we_o,
  output logic [IW+CW-1:0]  chr_waddr_o,
  output logic [CHAR_W-1:0] chr_wdata_o,
  output logic [IW+CW-1:0]  chr_raddr_o,
  input  logic [CHAR_W-1:0] chr_rdata_i,
  output logic              meta_we_o,
  output logic [IW-1:0]     meta_waddr_o,
  output iit_meta_t         meta_wdata_o,
  output logic [IW-1:0]     meta_raddr_o,
  input  iit_meta_t         meta_rdata_i
);

  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = $clog2(NAME_MAX + 1);

  iit_state_e        state_q, state_d;
  logic [LW-1:0]     plen_q, plen_d;
  logic [NW-1:0]     nf_q, nf_d;
  logic [IW-1:0]     e_q, e_d;
  logic [LW-1:0]     k_q, k_d;
  logic              cs_q, cs_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [CODE_W-1:0] ecode_q, ecode_d;
  logic [IDX_W-1:0]  res_index_q, res_index_d;
  logic [CODE_W-1:0] res_code_q, res_code_d;
  logic              res_added_q, res_added_d;
  logic              res_ovf_q, res_ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_index_q, out_index_d;
  logic [CODE_W-1:0] out_code_q, out_code_d;
  logic              out_added_q, out_added_d;
  logic              out_ovf_q, out_ovf_d;

  logic          in_acc;
  logic          cmp_eq;
  logic          next_entry;
  logic          go_insert;
  logic [LW-1:0] kn;
  logic [LW-1:0] km1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmp_eq     = (fold_char(chr_rdata_i, cs_q) == fold_char(pend_rdata_i, cs_q));
  assign km1        = k_q - 1'b1;

  assign pend_waddr_o = plen_q[CW-1:0];
  assign pend_wdata_o = ch_i;
  assign pend_raddr_o = kn[CW-1:0];
  assign chr_raddr_o  = {e_q, kn[CW-1:0]};
  assign chr_waddr_o  = {nf_q[IW-1:0], km1[CW-1:0]};
  assign chr_wdata_o  = pend_rdata_i;
  assign meta_raddr_o = e_q + 1'b1;
  assign meta_waddr_o = nf_q[IW-1:0];
  assign meta_wdata_o = '{len: LEN_W'(plen_q), code: code_q};

  assign out_valid_o  = out_valid_q;
  assign index_o      = out_index_q;
  assign entry_code_o = out_code_q;
  assign added_o      = out_added_q;
  assign overflow_o   = out_ovf_q;

  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    nf_d        = nf_q;
    e_d         = e_q;
    k_d         = k_q;
    cs_d        = cfg_we_i ? cfg_wdata_i : cs_q;
    code_d      = code_q;
    ecode_d     = ecode_q;
    res_index_d = res_index_q;
    res_code_d  = res_code_q;
    res_added_d = res_added_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_index_d = out_index_q;
    out_code_d  = out_code_q;
    out_added_d = out_added_q;
    out_ovf_d   = out_ovf_q;
    pend_we_o   = 1'b0;
    chr_we_o    = 1'b0;
    meta_we_o   = 1'b0;
    next_entry  = 1'b0;
    go_insert   = 1'b0;
    kn          = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            MODE_CLEAR: begin
              nf_d   = NW'(1);
              plen_d = '0;
            end
            MODE_LOOKUP, MODE_ADD: begin
              if (plen_q < LW'(NAME_MAX)) begin
                pend_we_o = 1'b1;
                plen_d    = plen_q + 1'b1;
              end
              if (last_i) begin
                code_d = code_i;
                if ((mode_i == MODE_LOOKUP) && (nf_q > NW'(1))) begin
                  e_d     = IW'(1);
                  state_d = ST_LEN;
                end else begin
                  go_insert = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_LEN: begin
        if (meta_rdata_i.len == LEN_W'(plen_q)) begin
          ecode_d = meta_rdata_i.code;
          k_d     = '0;
          state_d = ST_CHR;
        end else begin
          next_entry = 1'b1;
        end
      end
      ST_CHR: begin
        kn = k_q + 1'b1;
        if (!cmp_eq) begin
          next_entry = 1'b1;
        end else if (k_q == (plen_q - 1'b1)) begin
          res_index_d = IDX_W'(e_q);
          res_code_d  = ecode_q;
          res_added_d = 1'b0;
          res_ovf_d   = 1'b0;
          state_d     = ST_DONE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_COPY: begin
        kn       = k_q;
        chr_we_o = (k_q != '0);
        if (k_q == plen_q) begin
          meta_we_o   = 1'b1;
          res_index_d = IDX_W'(nf_q);
          res_code_d  = code_q;
          res_added_d = 1'b1;
          res_ovf_d   = 1'b0;
          nf_d        = nf_q + 1'b1;
          state_d     = ST_DONE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          out_index_d = res_index_q;
          out_code_d  = res_code_q;
          out_added_d = res_added_q;
          out_ovf_d   = res_ovf_q;
          plen_d      = '0;
          e_d         = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (next_entry) begin
      if ((NW'(e_q) + NW'(1)) < nf_q) begin
        e_d     = e_q + 1'b1;
        state_d = ST_LEN;
      end else begin
        go_insert = 1'b1;
      end
    end

    if (go_insert) begin
      if (nf_q >= NW'(TABLE_DEPTH)) begin
        res_index_d = '0;
        res_code_d  = '0;
        res_added_d = 1'b0;
        res_ovf_d   = 1'b1;
        state_d     = ST_DONE;
      end else begin
        k_d     = '0;
        state_d = ST_COPY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plen_q      <= '0;
      nf_q        <= NW'(1);
      e_q         <= '0;
      k_q         <= '0;
      cs_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      nf_q        <= nf_d;
      e_q         <= e_d;
      k_q         <= k_d;
      cs_q        <= cs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    ecode_q     <= ecode_d;
    res_index_q <= res_index_d;
    res_code_q  <= res_code_d;
    res_added_q <= res_added_d;
    res_ovf_q   <= res_ovf_d;
    out_index_q <= out_index_d;
    out_code_q  <= out_code_d;
    out_added_q <= out_added_d;
    out_ovf_q   <= out_ovf_d;
  end

endmodule

// ===== rtl/core/identifier_intern_table.sv =====
// channel  dir  handshake                     payload
// cfg      in   cfg_we_i                      cfg_wdata_i (case sensitive)
// in       in   in_valid_i / in_stall_o       mode_i ch_i last_i code_i
// out      out  out_valid_o / out_stall_i     index_o entry_code_o added_o overflow_o
//
// a character word, a clear word and an ignored word never stall the input.
// a final lookup word searches the occupied entries and inserts the name if
// none matches; a final add word inserts it without a search. the search checks
// each entry's length and compares the characters of each entry of equal length;
// the insert copies the name into the next free entry, or reports overflow.
// reset empties the table at once (next free index 1); no clearing pass.
// in_stall_o is high from a final word until its result sits in the output
// register; that register holds a result while out_stall_i is high.
module identifier_intern_table import iit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned NAME_MAX    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  logic              last_i,
  input  logic [CODE_W-1:0] code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  index_o,
  output logic [CODE_W-1:0] entry_code_o,
  output logic              added_o,
  output logic              overflow_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  logic              pend_we;
  logic [CW-1:0]     pend_waddr;
  logic [CHAR_W-1:0] pend_wdata;
  logic [CW-1:0]     pend_raddr;
  logic [CHAR_W-1:0] pend_rdata;
  logic              chr_we;
  logic [IW+CW-1:0]  chr_waddr;
  logic [CHAR_W-1:0] chr_wdata;
  logic [IW+CW-1:0]  chr_raddr;
  logic [CHAR_W-1:0] chr_rdata;
  logic              meta_we;
  logic [IW-1:0]     meta_waddr;
  iit_meta_t         meta_wdata;
  logic [IW-1:0]     meta_raddr;
  iit_meta_t         meta_rdata;

  iit_pend_buf #(
    .NAME_MAX(NAME_MAX)
  ) u_pend (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(pend_waddr),
    .wdata_i(pend_wdata),
    .raddr_i(pend_raddr),
    .rdata_o(pend_rdata)
  );

  iit_entry_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_MAX   (NAME_MAX)
  ) u_store (
    .clk_i       (clk_i),
    .chr_we_i    (chr_we),
    .chr_waddr_i (chr_waddr),
    .chr_wdata_i (chr_wdata),
    .chr_raddr_i (chr_raddr),
    .chr_rdata_o (chr_rdata),
    .meta_we_i   (meta_we),
    .meta_waddr_i(meta_waddr),
    .meta_wdata_i(meta_wdata),
    .meta_raddr_i(meta_raddr),
    .meta_rdata_o(meta_rdata)
  );

  iit_search_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_MAX   (NAME_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .code_i      (code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .index_o     (index_o),
    .entry_code_o(entry_code_o),
    .added_o     (added_o),
    .overflow_o  (overflow_o),
    .pend_we_o   (pend_we),
    .pend_waddr_o(pend_waddr),
    .pend_wdata_o(pend_wdata),
    .pend_raddr_o(pend_raddr),
    .pend_rdata_i(pend_rdata),
    .chr_we_o    (chr_we),
    .chr_waddr_o (chr_waddr),
    .chr_wdata_o (chr_wdata),
    .chr_raddr_o (chr_raddr),
    .chr_rdata_i (chr_rdata),
    .meta_we_o   (meta_we),
    .meta_waddr_o(meta_waddr),
    .meta_wdata_o(meta_wdata),
    .meta_raddr_o(meta_raddr),
    .meta_rdata_i(meta_rdata)
  );

endmodule

// ===== rtl/core/iit_checker.sv =====
module iit_prop_checker import iit_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        mode_i,
  input logic              last_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [IDX_W-1:0]  index_o,
  input logic [CODE_W-1:0] entry_code_o,
  input logic              added_o,
  input logic              overflow_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(index_o) &&
      $stable(entry_code_o) && $stable(added_o) && $stable(overflow_o))
    else $error("result word changed while stalled");

  // overflow result carries no entry
  a_ovf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> (index_o == '0) && (entry_code_o == '0) && !added_o)
    else $error("overflow result with entry data");

  // a word that ends no name never blocks the next one
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
      (!last_i || (mode_i == MODE_CLEAR) || (mode_i == MODE_NONE)) |=> !in_stall_o)
    else $error("stall after a word without search");

  // a final word starts a search or insert
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i &&
      ((mode_i == MODE_LOOKUP) || (mode_i == MODE_ADD)) |=> in_stall_o)
    else $error("final word did not start a search");

endmodule

bind identifier_intern_table iit_prop_checker u_iit_checker (.*);
